// File: sv/shpw_pkg.sv
// Package for the spatial hash point welder: item types, register constants,
// outcome codes, multiplier operation codes and the controller/datapath links.
// Depends on nothing; every other file imports it.
`default_nettype none

package shpw_pkg;

  // Field widths fixed by the interface.
  localparam int TOL_W      = 20;
  localparam int INV_W      = 30;
  localparam int NODE_OUT_W = 11;
  localparam int PADDR_W    = 3;

  // Register reset values and the smallest usable snap distance.
  localparam logic [TOL_W-1:0] TOL_RESET = 20'd655;
  localparam logic [INV_W-1:0] INV_RESET = 30'd6553600;
  localparam logic [TOL_W-1:0] MIN_TOL   = 20'd7;

  // Register select bit of the byte address (registers sit 4 bytes apart).
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_INV_TOL   = 1'b1;

  // One input item: a point in signed Q16.16.
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef enum logic [1:0] {
    OUT_FOUND       = 2'd0,
    OUT_CREATED     = 2'd1,
    OUT_STORE_FULL  = 2'd2,
    OUT_BUCKET_FULL = 2'd3
  } outcome_t;

  // One result item.
  typedef struct packed {
    logic [NODE_OUT_W-1:0] node_number;
    outcome_t              outcome;
  } result_t;

  // Jobs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_X   = 3'd0,
    MUL_Y   = 3'd1,
    MUL_Z   = 3'd2,
    MUL_TOL = 3'd3,
    MUL_SX  = 3'd4,
    MUL_SY  = 3'd5,
    MUL_SZ  = 3'd6
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     mul_go;
    logic     mul_store;
    mul_op_t  mul_op;
    logic     nb_init;
    logic     nb_step;
    logic     own_cell;
    logic     hash_start;
    logic     w_inc;
    logic     ax_load;
    logic     sq_clr;
    logic     sq_acc;
    logic     insert;
    logic     res_load;
    outcome_t res_code;
  } shpw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_busy;
    logic mod_done;
    logic w_ge_fill;
    logic cell_match;
    logic axis_ok;
    logic dist_ok;
    logic nb_last;
    logic store_full;
    logic bucket_full;
    logic out_free;
  } shpw_status_t;

endpackage

`default_nettype wire

// File: sv/spatial_hash_point_welder_top.sv
// Top level of the spatial hash point welder: configuration registers on the
// register port, controller and datapath. Depends on shpw_pkg, shpw_ctrl, shpw_dp.
//
//   Port group   Direction  Contents
//   in_*         in         point_x, point_y, point_z (signed Q16.16), valid/stall
//   out_*        out        node_number, outcome, valid/stall
//   p*           in/out     tolerance at 0x0, inverse_tolerance at 0x4
//
// After reset the bucket fill memory is cleared; no item is taken meanwhile.
// An item is accepted, its cells and squared tolerance are computed, then
// each of the 27 neighbor cells is hashed (a longer reduction when HASH_BUCKETS
// is not a power of two) and its ways are read, with a node compare on each
// cell match and a distance check after it; then own-cell lookup, insert, hand-off.
// A result waits in the output register while out_stall is high.
`default_nettype none

module spatial_hash_point_welder_top #(
  parameter int MAX_NODES    = 1024,
  parameter int HASH_BUCKETS = 256,
  parameter int BUCKET_WAYS  = 8
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  shpw_pkg::point_t               in_item,
  output logic                           out_valid,
  input  wire                            out_stall,
  output shpw_pkg::result_t              out_item,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [shpw_pkg::PADDR_W-1:0]   paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import shpw_pkg::*;

  logic [TOL_W-1:0] tolerance;
  logic [INV_W-1:0] inverse_tolerance;
  shpw_cmd_t        cmd;
  shpw_status_t     status;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance         <= TOL_RESET;
      inverse_tolerance <= INV_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TOLERANCE) begin
        tolerance <= pwdata[TOL_W-1:0];
      end else begin
        inverse_tolerance <= pwdata[INV_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_INV_TOL) ? 32'(inverse_tolerance) : 32'(tolerance);

  shpw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  shpw_dp #(
    .MAX_NODES    (MAX_NODES),
    .HASH_BUCKETS (HASH_BUCKETS),
    .BUCKET_WAYS  (BUCKET_WAYS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_item           (in_item),
    .tolerance         (tolerance),
    .inverse_tolerance (inverse_tolerance),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item          (out_item)
  );

endmodule

`default_nettype wire

// File: sv/shpw_dp.sv
// Datapath of the point welder: point and cell registers, shared multiplier,
// bucket hash reduction, node, slot and bucket fill memories, output register.
// Depends on shpw_pkg; driven by shpw_ctrl.
`default_nettype none

module shpw_dp #(
  parameter int MAX_NODES    = 1024,
  parameter int HASH_BUCKETS = 256,
  parameter int BUCKET_WAYS  = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  shpw_pkg::point_t             in_item,
  input  wire  [shpw_pkg::TOL_W-1:0]   tolerance,
  input  wire  [shpw_pkg::INV_W-1:0]   inverse_tolerance,
  input  shpw_pkg::shpw_cmd_t          cmd,
  output shpw_pkg::shpw_status_t       status,
  output logic                         out_valid,
  input  wire                          out_stall,
  output shpw_pkg::result_t            out_item
);
  import shpw_pkg::*;

  localparam int NSW       = $clog2(MAX_NODES + 1);
  localparam int NAW       = $clog2(MAX_NODES);
  localparam int BKW       = $clog2(HASH_BUCKETS);
  localparam int FW        = $clog2(BUCKET_WAYS + 1);
  localparam int SLOTS     = HASH_BUCKETS * BUCKET_WAYS;
  localparam int SAW       = $clog2(SLOTS);
  localparam bit HB_POW2   = (HASH_BUCKETS & (HASH_BUCKETS - 1)) == 0;
  localparam logic [BKW-1:0] HB_TOP = BKW'(HASH_BUCKETS - 1);
  // Rounded-up reciprocal of the bucket count, scaled by 2^(32+BKW).
  localparam logic [63:0] HB_M = ((64'd1 << (32 + BKW)) + 64'(HASH_BUCKETS) - 64'd1) /
                                 64'(HASH_BUCKETS);

  typedef struct packed {
    logic [NSW-1:0] node;
    logic [31:0]    kx;
    logic [31:0]    ky;
    logic [31:0]    kz;
  } slot_t;

  function automatic logic [31:0] ofs(input logic [1:0] i);
    logic [31:0] r;
    case (i)
      2'd0:    r = 32'hFFFF_FFFF;
      2'd1:    r = 32'd0;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  // The difference of two 32-bit signed values needs 33 bits with its sign.
  function automatic logic [32:0] absdiff(input logic [31:0] a, input logic [31:0] b);
    logic [33:0] d;
    d = {{2{a[31]}}, a} - {{2{b[31]}}, b};
    return d[33] ? 33'(34'd0 - d) : d[32:0];
  endfunction

  point_t            pt;
  logic [31:0]       cx, cy, cz;
  logic [39:0]       tolsq;
  logic [TOL_W-1:0]  tol_eff;
  logic signed [32:0] ma, mb;
  logic [63:0]       mul_p;
  logic [TOL_W-1:0]  ax, ay, az;
  logic [41:0]       sq;
  logic [1:0]        ix, iy, iz;
  logic [31:0]       kx, ky, kz, h;
  logic [BKW-1:0]    bk;
  logic [31:0]       hsh;
  logic [64:0]       qprod;
  logic [31:0]       qv;
  logic [1:0]        mcnt;
  logic              mod_busy;
  logic              clr_busy;
  logic [BKW-1:0]    clr_idx;
  logic [FW-1:0]     fill_mem [HASH_BUCKETS];
  logic [FW-1:0]     fill_q;
  logic [FW-1:0]     w;
  slot_t             slot_mem [SLOTS];
  slot_t             slot_q;
  logic [SAW-1:0]    slot_addr, ins_addr;
  point_t            node_mem [MAX_NODES];
  point_t            node_q;
  logic [NAW-1:0]    node_idx;
  logic [NSW-1:0]    nodes_stored;
  logic [32:0]       adx, ady, adz;
  logic [31:0]       nn_wide;

  assign tol_eff = (tolerance < MIN_TOL) ? MIN_TOL : tolerance;

  // Input point register.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt <= in_item;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MUL_X:   begin ma = {pt.point_x[31], pt.point_x}; mb = {3'b000, inverse_tolerance}; end
      MUL_Y:   begin ma = {pt.point_y[31], pt.point_y}; mb = {3'b000, inverse_tolerance}; end
      MUL_Z:   begin ma = {pt.point_z[31], pt.point_z}; mb = {3'b000, inverse_tolerance}; end
      MUL_TOL: begin ma = {13'd0, tol_eff}; mb = {13'd0, tol_eff}; end
      MUL_SX:  begin ma = {13'd0, ax}; mb = {13'd0, ax}; end
      MUL_SY:  begin ma = {13'd0, ay}; mb = {13'd0, ay}; end
      MUL_SZ:  begin ma = {13'd0, az}; mb = {13'd0, az}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Registered product, then cell floor (upper word), squared tolerance or square accumulation.
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mul_p <= 64'(66'(ma) * 66'(mb));
    end
    if (cmd.mul_store) begin
      case (cmd.mul_op)
        MUL_X:   cx <= mul_p[63:32];
        MUL_Y:   cy <= mul_p[63:32];
        MUL_Z:   cz <= mul_p[63:32];
        MUL_TOL: tolsq <= mul_p[39:0];
        default: ;
      endcase
    end
    if (cmd.sq_clr) begin
      sq <= '0;
    end else if (cmd.sq_acc) begin
      sq <= sq + 42'(mul_p[39:0]);
    end
    if (cmd.ax_load) begin
      ax <= adx[TOL_W-1:0];
      ay <= ady[TOL_W-1:0];
      az <= adz[TOL_W-1:0];
    end
  end

  // Neighbor cell walk: x outermost, z innermost.
  always_ff @(posedge clk) begin
    if (cmd.nb_init) begin
      ix <= 2'd0;
      iy <= 2'd0;
      iz <= 2'd0;
    end else if (cmd.nb_step) begin
      if (iz == 2'd2) begin
        iz <= 2'd0;
        if (iy == 2'd2) begin
          iy <= 2'd0;
          ix <= ix + 2'd1;
        end else begin
          iy <= iy + 2'd1;
        end
      end else begin
        iz <= iz + 2'd1;
      end
    end
  end

  assign kx = cx + (cmd.own_cell ? 32'd0 : ofs(ix));
  assign ky = cy + (cmd.own_cell ? 32'd0 : ofs(iy));
  assign kz = cz + (cmd.own_cell ? 32'd0 : ofs(iz));
  assign h  = kx ^ (ky << 1) ^ (kz << 2);

  // Bucket index: a mask for a power-of-two bucket count, else a reciprocal
  // multiplication for the quotient and a subtraction for the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
    end else if (cmd.hash_start) begin
      if (HB_POW2) begin
        bk <= h[BKW-1:0];
      end else begin
        hsh      <= h;
        mcnt     <= 2'd0;
        mod_busy <= 1'b1;
      end
    end else if (mod_busy) begin
      mcnt <= mcnt + 2'd1;
      case (mcnt)
        2'd0:    qprod <= 65'(hsh) * 65'(HB_M[32:0]);
        2'd1:    qv <= 32'(qprod >> (32 + BKW));
        default: begin
          bk       <= BKW'(hsh - qv * 32'(HASH_BUCKETS));
          mod_busy <= 1'b0;
        end
      endcase
    end
  end

  // Way counter within the current bucket.
  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      w <= '0;
    end else if (cmd.w_inc) begin
      w <= w + FW'(1);
    end
  end

  // Clearing pass over the bucket fill memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + BKW'(1);
      if (clr_idx == HB_TOP) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Bucket fill memory.
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      fill_mem[clr_idx] <= '0;
    end else if (cmd.insert) begin
      fill_mem[bk] <= fill_q + FW'(1);
    end
    fill_q <= fill_mem[bk];
  end

  assign slot_addr = SAW'(bk) * SAW'(BUCKET_WAYS) + SAW'(w);
  assign ins_addr  = SAW'(bk) * SAW'(BUCKET_WAYS) + SAW'(fill_q);

  // Slot memory: cell and node number of each filed node.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      slot_mem[ins_addr] <= '{node: nodes_stored + NSW'(1), kx: cx, ky: cy, kz: cz};
    end
    slot_q <= slot_mem[slot_addr];
  end

  assign node_idx = NAW'(slot_q.node - NSW'(1));

  // Node position memory.
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      node_mem[nodes_stored[NAW-1:0]] <= pt;
    end
    node_q <= node_mem[node_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_stored <= '0;
    end else if (cmd.insert) begin
      nodes_stored <= nodes_stored + NSW'(1);
    end
  end

  // Per-axis distance against the effective tolerance.
  assign adx = absdiff(node_q.point_x, pt.point_x);
  assign ady = absdiff(node_q.point_y, pt.point_y);
  assign adz = absdiff(node_q.point_z, pt.point_z);

  // Output register.
  always_comb begin
    case (cmd.res_code)
      OUT_FOUND:   nn_wide = 32'(slot_q.node);
      OUT_CREATED: nn_wide = 32'(nodes_stored);
      default:     nn_wide = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item.node_number <= nn_wide[NODE_OUT_W-1:0];
      out_item.outcome     <= cmd.res_code;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.clear_busy  = clr_busy;
    status.mod_done    = !mod_busy;
    status.w_ge_fill   = w >= fill_q;
    status.cell_match  = (slot_q.kx == kx) && (slot_q.ky == ky) && (slot_q.kz == kz);
    status.axis_ok     = (adx <= 33'(tol_eff)) && (ady <= 33'(tol_eff)) &&
                         (adz <= 33'(tol_eff));
    status.dist_ok     = sq <= 42'(tolsq);
    status.nb_last     = (ix == 2'd2) && (iy == 2'd2) && (iz == 2'd2);
    status.store_full  = nodes_stored >= NSW'(MAX_NODES);
    status.bucket_full = fill_q >= FW'(BUCKET_WAYS);
    status.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// File: sv/shpw_ctrl.sv
// Controller of the point welder: one-hot state machine that sequences cell
// computation, the neighbor search, the insert and the result hand-off.
// Depends on shpw_pkg; drives shpw_dp.
`default_nettype none

module shpw_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  output shpw_pkg::shpw_cmd_t     cmd,
  input  shpw_pkg::shpw_status_t  status
);
  import shpw_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'h0001,
    S_CELL   = 15'h0002,
    S_CELLA  = 15'h0004,
    S_HASH   = 15'h0008,
    S_HWAIT  = 15'h0010,
    S_RD     = 15'h0020,
    S_SCMP   = 15'h0040,
    S_NODE   = 15'h0080,
    S_SQ     = 15'h0100,
    S_SQA    = 15'h0200,
    S_DCHK   = 15'h0400,
    S_NEXTNB = 15'h0800,
    S_INSCHK = 15'h1000,
    S_INS    = 15'h2000,
    S_DONE   = 15'h4000
  } state_t;

  state_t   state, state_next;
  logic [1:0] cnt, cnt_next;
  logic     own, own_next;
  outcome_t res_code, res_code_next;

  assign in_stall = !((state == S_IDLE) && !status.clear_busy);

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    own_next      = own;
    res_code_next = res_code;
    cmd           = '0;
    cmd.own_cell  = own;
    cmd.res_code  = res_code;
    cmd.mul_op    = MUL_X;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          cnt_next   = 2'd0;
          own_next   = 1'b0;
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = mul_op_t'({1'b0, cnt});
        state_next = S_CELLA;
      end
      S_CELLA: begin
        cmd.mul_store = 1'b1;
        cmd.mul_op    = mul_op_t'({1'b0, cnt});
        if (cnt == 2'd3) begin
          cmd.nb_init = 1'b1;
          state_next  = S_HASH;
        end else begin
          cnt_next   = cnt + 2'd1;
          state_next = S_CELL;
        end
      end
      S_HASH: begin
        cmd.hash_start = 1'b1;
        state_next     = S_HWAIT;
      end
      S_HWAIT: begin
        if (status.mod_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = own ? S_INSCHK : S_SCMP;
      end
      S_SCMP: begin
        if (status.w_ge_fill) begin
          state_next = S_NEXTNB;
        end else if (status.cell_match) begin
          state_next = S_NODE;
        end else begin
          cmd.w_inc  = 1'b1;
          state_next = S_RD;
        end
      end
      S_NODE: begin
        if (status.axis_ok) begin
          cmd.ax_load = 1'b1;
          cmd.sq_clr  = 1'b1;
          cnt_next    = 2'd0;
          state_next  = S_SQ;
        end else begin
          cmd.w_inc  = 1'b1;
          state_next = S_RD;
        end
      end
      S_SQ: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = mul_op_t'({1'b1, cnt});
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.sq_acc = 1'b1;
        if (cnt == 2'd2) begin
          state_next = S_DCHK;
        end else begin
          cnt_next   = cnt + 2'd1;
          state_next = S_SQ;
        end
      end
      S_DCHK: begin
        if (status.dist_ok) begin
          res_code_next = OUT_FOUND;
          state_next    = S_DONE;
        end else begin
          cmd.w_inc  = 1'b1;
          state_next = S_RD;
        end
      end
      S_NEXTNB: begin
        if (!status.nb_last) begin
          cmd.nb_step = 1'b1;
          state_next  = S_HASH;
        end else if (status.store_full) begin
          res_code_next = OUT_STORE_FULL;
          state_next    = S_DONE;
        end else begin
          own_next   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_INSCHK: begin
        if (status.bucket_full) begin
          res_code_next = OUT_BUCKET_FULL;
          state_next    = S_DONE;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.insert    = 1'b1;
        res_code_next = OUT_CREATED;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= 2'd0;
      own      <= 1'b0;
      res_code <= OUT_FOUND;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      own      <= own_next;
      res_code <= res_code_next;
    end
  end

`ifndef SYNTHESIS
  // An insert only happens with room in both the node store and the bucket.
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (!status.store_full && !status.bucket_full))
    else $error("insert issued while a store is full");

  // A result is loaded only when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> status.out_free)
    else $error("result loaded over a waiting item");

  // No item is taken while the fill memory is being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> !status.clear_busy)
    else $error("item accepted during clearing pass");

  // A cell match on a live way always leads to the node compare.
  a_match_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCMP && !status.w_ge_fill && status.cell_match) |=> (state == S_NODE))
    else $error("cell match not followed by node compare");
`endif

endmodule

`default_nettype wire

// File: sim/tb_spatial_hash_point_welder_top.sv
// Testbench for the spatial hash point welder: drives points, writes the snap
// registers over the register port and checks every result against a predictor.
// Depends on shpw_pkg and spatial_hash_point_welder_top.
`timescale 1ns / 100ps

// Predicts welder results and holds the queue of expected results.
class weld_scoreboard;
  localparam int NODES = 1024;
  localparam int BUCKETS = 256;
  localparam int WAYS = 8;

  logic [19:0] tol_reg;
  logic [29:0] inv_reg;
  int signed pos_x [NODES];
  int signed pos_y [NODES];
  int signed pos_z [NODES];
  int unsigned node_count;
  int unsigned fill [BUCKETS];
  int unsigned way_node [BUCKETS*WAYS];
  int signed way_cx [BUCKETS*WAYS];
  int signed way_cy [BUCKETS*WAYS];
  int signed way_cz [BUCKETS*WAYS];
  shpw_pkg::result_t pending [$];
  int errors;
  int checked;
  int outcome_seen [4];

  function new();
    tol_reg = shpw_pkg::TOL_RESET;
    inv_reg = shpw_pkg::INV_RESET;
    node_count = 0;
    foreach (fill[i]) fill[i] = 0;
    errors = 0;
    checked = 0;
  endfunction

  // Floor of p * inv / 2^32 using an exact 64-bit product.
  function int signed cell_of(int signed p);
    longint signed prod;
    prod = longint'(p) * longint'({34'd0, inv_reg});
    return int'(prod >>> 32);
  endfunction

  function int unsigned bucket_of(int signed cx, int signed cy, int signed cz);
    logic [31:0] h;
    h = cx ^ (cy << 1) ^ (cz << 2);
    return h % BUCKETS;
  endfunction

  function bit near(int unsigned node, int signed x, int signed y, int signed z,
                    longint unsigned tol);
    longint unsigned ax, ay, az;
    longint signed d;
    d = longint'(pos_x[node-1]) - longint'(x); ax = d < 0 ? -d : d;
    d = longint'(pos_y[node-1]) - longint'(y); ay = d < 0 ? -d : d;
    d = longint'(pos_z[node-1]) - longint'(z); az = d < 0 ? -d : d;
    if (ax > tol || ay > tol || az > tol) return 0;
    return ax*ax + ay*ay + az*az <= tol*tol;
  endfunction

  // Notes an accepted point: search neighbors, else insert.
  function void note_point(shpw_pkg::point_t p);
    int signed cx, cy, cz, kx, ky, kz;
    int unsigned b, s;
    longint unsigned tol;
    shpw_pkg::result_t r;
    cx = cell_of(p.point_x); cy = cell_of(p.point_y); cz = cell_of(p.point_z);
    tol = tol_reg < shpw_pkg::MIN_TOL ? 64'(shpw_pkg::MIN_TOL) : 64'(tol_reg);
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++) begin
          kx = cx + dx; ky = cy + dy; kz = cz + dz;
          b = bucket_of(kx, ky, kz);
          for (int w = 0; w < fill[b]; w++) begin
            s = b*WAYS + w;
            if (way_cx[s] == kx && way_cy[s] == ky && way_cz[s] == kz &&
                near(way_node[s], p.point_x, p.point_y, p.point_z, tol)) begin
              r.node_number = 11'(way_node[s]);
              r.outcome = shpw_pkg::OUT_FOUND;
              pending = {pending, r};
              return;
            end
          end
        end
    b = bucket_of(cx, cy, cz);
    r.node_number = '0;
    if (node_count >= NODES) begin
      r.outcome = shpw_pkg::OUT_STORE_FULL;
    end else if (fill[b] >= WAYS) begin
      r.outcome = shpw_pkg::OUT_BUCKET_FULL;
    end else begin
      pos_x[node_count] = p.point_x;
      pos_y[node_count] = p.point_y;
      pos_z[node_count] = p.point_z;
      node_count++;
      s = b*WAYS + fill[b];
      way_node[s] = node_count;
      way_cx[s] = cx; way_cy[s] = cy; way_cz[s] = cz;
      fill[b]++;
      r.node_number = 11'(node_count);
      r.outcome = shpw_pkg::OUT_CREATED;
    end
    pending = {pending, r};
  endfunction

  // Compares one result with the oldest expectation.
  function void check_result(shpw_pkg::result_t got);
    shpw_pkg::result_t want;
    checked++;
    outcome_seen[got.outcome]++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result node %0d outcome %0d",
                                 got.node_number, got.outcome);
      return;
    end
    want = pending.pop_front();
    if (got.node_number !== want.node_number || got.outcome !== want.outcome) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %0t: node exp %0d got %0d, outcome exp %0d got %0d",
                 $realtime, want.node_number, got.node_number, want.outcome,
                 got.outcome);
    end
  endfunction
endclass

module tb_spatial_hash_point_welder_top;
  import shpw_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  point_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  weld_scoreboard welds;
  bit hold_out = 1'b0;
  int sent;
  int stall_clk = 0;

  spatial_hash_point_welder_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Input and result monitor.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) welds.note_point(in_item);
    if (!rst && out_valid && !out_stall) welds.check_result(out_item);
  end

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    stall_clk <= stall_clk + 1;
    if (hold_out) out_stall <= 1'b1;
    else if ((stall_clk / 400) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == REG_INV_TOL) welds.inv_reg = data[29:0];
    else welds.tol_reg = data[19:0];
  endtask

  // Waits until all results are back and the block has settled.
  task automatic drain();
    while (welds.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    in_valid <= 1'b1;
    in_item <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random point, in half the cases near the last point so that welds happen.
  function automatic point_t rand_point(point_t last);
    point_t p;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      p.point_x = last.point_x + $signed($urandom_range(0, 2000)) - 1000;
      p.point_y = last.point_y + $signed($urandom_range(0, 2000)) - 1000;
      p.point_z = last.point_z + $signed($urandom_range(0, 2000)) - 1000;
    end else if (mode < 8) begin
      p.point_x = $signed($urandom_range(0, 400000)) - 200000;
      p.point_y = $signed($urandom_range(0, 400000)) - 200000;
      p.point_z = $signed($urandom_range(0, 400000)) - 200000;
    end else begin
      p.point_x = $urandom; p.point_y = $urandom; p.point_z = $urandom;
    end
    return p;
  endfunction

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    point_t p, last;
    int burst;
    welds = new();
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    repeat (300) @(posedge clk);

    // Directed: extremes, repeats, near points and a wide tolerance.
    reg_write(3'h0, 32'd0);
    reg_write(3'h4, 32'd655360000);
    send_point('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_point('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    send_point('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_point('{0, 0, 0});
    send_point('{7, 0, 0});
    send_point('{8, 0, 0});
    send_point('{-1, -1, -1});
    send_point('{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f});
    in_valid <= 1'b0;
    drain();
    reg_write(3'h0, 32'd655360);
    reg_write(3'h4, 32'd6554);
    send_point('{0, 0, 0});
    send_point('{655360, 0, 0});
    send_point('{655361, 0, 0});
    send_point('{463412, 463412, 0});
    in_valid <= 1'b0;
    drain();
    // Zero inverse tolerance: one cell, so its bucket fills.
    reg_write(3'h4, 32'd0);
    reg_write(3'h0, 32'd7);
    for (int i = 0; i < 10; i++) send_point('{i * 1000, 5, -5});
    in_valid <= 1'b0;
    drain();

    // Random phases with several settings; one phase under a long hold-off.
    last = '0;
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(3'h0, (ph == 0) ? 32'd655 : $urandom_range(7, 4000));
      reg_write(3'h4, (ph == 5) ? 32'd655360000 : $urandom_range(6554, 20000000));
      if (ph == 2) fork
        begin
          hold_out = 1'b1;
          repeat (3000) @(posedge clk);
          hold_out = 1'b0;
        end
      join_none
      for (int n = 0; n < 200; n++) begin
        burst = $urandom_range(1, 12);
        p = rand_point(last);
        last = p;
        send_point(p);
        if (n % burst == 0) idle_gap();
      end
      in_valid <= 1'b0;
      drain();
    end

    // Fill the node store to reach its full case.
    reg_write(3'h0, 32'd7);
    reg_write(3'h4, 32'd6553600);
    while (welds.node_count < 1024 || welds.outcome_seen[OUT_STORE_FULL] < 20) begin
      p.point_x = $urandom; p.point_y = $urandom; p.point_z = $urandom;
      send_point(p);
      if (sent > 1500) break;
    end
    in_valid <= 1'b0;
    drain();

    $display("covered %0d points, %0d results: found %0d created %0d full %0d/%0d",
             sent, welds.checked, welds.outcome_seen[0], welds.outcome_seen[1],
             welds.outcome_seen[2], welds.outcome_seen[3]);
    if (welds.errors == 0 && welds.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("errors: %0d", welds.errors);
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
sv/shpw_pkg.sv
sv/shpw_dp.sv
sv/shpw_ctrl.sv
sv/spatial_hash_point_welder_top.sv
sim/tb_spatial_hash_point_welder_top.sv
